// ===== sv/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types, letter classes and the per-position encode function.
// ----------------------------------------------------------------------------
`default_nettype none

package mpe_pkg;

    localparam logic [7:0] SH_CODE = "X";
    localparam logic [7:0] TH_CODE = "0";

    localparam logic [4:0] F_VOWEL   = 5'd1;
    localparam logic [4:0] F_AFFECTH = 5'd4;
    localparam logic [4:0] F_SOFT    = 5'd8;
    localparam logic [4:0] F_NOGHF   = 5'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PHASE_LEAD = 2'd0,
        PHASE_MAIN = 2'd1,
        PHASE_STOP = 2'd2
    } phase_t;

    typedef logic [7:0][7:0] window_t;

    typedef struct packed {
        logic [7:0] ph0;
        logic [7:0] ph1;
        logic [1:0] nph;
        logic       eow;
    } entry_t;

    typedef struct packed {
        logic [7:0] ph0;
        logic [7:0] ph1;
        logic [1:0] nph;
        logic       skip;
        phase_t     phase;
    } step_t;

    localparam logic [4:0] LETTER_CLASS [26] = '{
        5'd1, 5'd16, 5'd4, 5'd16, 5'd9, 5'd2, 5'd4, 5'd16, 5'd9, 5'd2, 5'd0, 5'd2, 5'd2,
        5'd2, 5'd1, 5'd4, 5'd0, 5'd2, 5'd4, 5'd4, 5'd1, 5'd0, 5'd0, 5'd0, 5'd8, 5'd0
    };

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic [4:0] class_of(logic [7:0] c);
        logic [7:0] idx;
        idx = c - 8'd65;
        return is_letter(c) ? LETTER_CLASS[idx[4:0]] : 5'd0;
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

    function automatic step_t encode(window_t w, logic skip, phase_t phase,
                                     logic [7:0] cnt, logic [7:0] maxlen);
        step_t      r;
        logic [7:0] c, pv, nx, an, a3, b3, b4, p;
        logic       go, emit, lskip, dbl;
        logic [1:0] adv;
        r     = '0;
        r.skip  = skip;
        r.phase = phase;
        c  = w[4];
        pv = w[3];
        nx = w[5];
        an = (nx != 8'd0) ? w[6] : 8'd0;
        a3 = (an != 8'd0) ? w[7] : 8'd0;
        b3 = w[1];
        b4 = w[0];
        p     = 8'd0;
        emit  = 1'b0;
        dbl   = 1'b0;
        lskip = 1'b0;
        go    = 1'b0;
        adv   = 2'd0;
        if (c == 8'd0 || phase == PHASE_STOP)
        begin
            go = 1'b0;
        end
        else if (skip)
        begin
            r.skip = 1'b0;
        end
        else
        begin
            go = 1'b1;
            if (phase == PHASE_LEAD)
            begin
                if (!is_letter(c))
                begin
                    go = 1'b0;
                end
                else
                begin
                    r.phase = PHASE_MAIN;
                    case (c) inside
                        "A":
                        begin
                            emit = 1'b1;
                            if (nx == "E")
                            begin
                                p   = "E";
                                adv = 2'd2;
                            end
                            else
                            begin
                                p   = "A";
                                adv = 2'd1;
                            end
                        end
                        "G", "K", "P":
                        begin
                            if (nx == "N")
                            begin
                                emit = 1'b1;
                                p    = "N";
                                adv  = 2'd2;
                            end
                        end
                        "W":
                        begin
                            if (nx == "R")
                            begin
                                emit = 1'b1;
                                p    = "R";
                                adv  = 2'd2;
                            end
                            else if (nx == "H" || (class_of(nx) & F_VOWEL) != 5'd0)
                            begin
                                emit = 1'b1;
                                p    = "W";
                                adv  = 2'd2;
                            end
                        end
                        "X":
                        begin
                            emit = 1'b1;
                            p    = "S";
                            adv  = 2'd1;
                        end
                        "E", "I", "O", "U":
                        begin
                            emit = 1'b1;
                            p    = c;
                            adv  = 2'd1;
                        end
                        default:
                        begin
                            adv = 2'd0;
                        end
                    endcase
                    if (adv != 2'd0)
                    begin
                        go = 1'b0;
                    end
                    if (adv == 2'd2)
                    begin
                        r.skip = 1'b1;
                    end
                end
            end
            if (go)
            begin
                if (maxlen != 8'd0 && cnt >= maxlen)
                begin
                    r.phase = PHASE_STOP;
                end
                else if (is_letter(c) && !(c == pv && c != "C"))
                begin
                    case (c) inside
                        "B":
                        begin
                            emit = (pv != "M");
                            p    = "B";
                        end
                        "C":
                        begin
                            if ((class_of(nx) & F_SOFT) != 5'd0)
                            begin
                                if (an == "A" && nx == "I")
                                begin
                                    emit = 1'b1;
                                    p    = SH_CODE;
                                end
                                else
                                begin
                                    emit = (pv != "S");
                                    p    = "S";
                                end
                            end
                            else if (nx == "H")
                            begin
                                emit  = 1'b1;
                                p     = SH_CODE;
                                lskip = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                                p    = "K";
                            end
                        end
                        "D":
                        begin
                            emit = 1'b1;
                            if (nx == "G" && (class_of(an) & F_SOFT) != 5'd0)
                            begin
                                p     = "J";
                                lskip = 1'b1;
                            end
                            else
                            begin
                                p = "T";
                            end
                        end
                        "G":
                        begin
                            if (nx == "H")
                            begin
                                if (!((class_of(b3) & F_NOGHF) != 5'd0 || b4 == "H"))
                                begin
                                    emit  = 1'b1;
                                    p     = "F";
                                    lskip = 1'b1;
                                end
                            end
                            else if (nx == "N")
                            begin
                                emit = !(!is_letter(an) || (an == "E" && a3 == "D"));
                                p    = "K";
                            end
                            else if ((class_of(nx) & F_SOFT) != 5'd0 && pv != "G")
                            begin
                                emit = 1'b1;
                                p    = "J";
                            end
                            else
                            begin
                                emit = 1'b1;
                                p    = "K";
                            end
                        end
                        "H":
                        begin
                            emit = (class_of(nx) & F_VOWEL) != 5'd0
                                && (class_of(pv) & F_AFFECTH) == 5'd0;
                            p    = "H";
                        end
                        "K":
                        begin
                            emit = (pv != "C");
                            p    = "K";
                        end
                        "P":
                        begin
                            emit = 1'b1;
                            p    = (nx == "H") ? "F" : "P";
                        end
                        "Q":
                        begin
                            emit = 1'b1;
                            p    = "K";
                        end
                        "S", "T":
                        begin
                            emit = 1'b1;
                            if (nx == "I" && (an == "O" || an == "A"))
                            begin
                                p = SH_CODE;
                            end
                            else if (nx == "H")
                            begin
                                p     = (c == "S") ? SH_CODE : TH_CODE;
                                lskip = 1'b1;
                            end
                            else if (c == "S")
                            begin
                                p = "S";
                            end
                            else
                            begin
                                emit = !(nx == "C" && an == "H");
                                p    = "T";
                            end
                        end
                        "V":
                        begin
                            emit = 1'b1;
                            p    = "F";
                        end
                        "W", "Y":
                        begin
                            emit = (class_of(nx) & F_VOWEL) != 5'd0;
                            p    = c;
                        end
                        "X":
                        begin
                            dbl = 1'b1;
                        end
                        "Z":
                        begin
                            emit = 1'b1;
                            p    = "S";
                        end
                        "F", "J", "L", "M", "N", "R":
                        begin
                            emit = 1'b1;
                            p    = c;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                    r.skip = lskip;
                end
            end
        end
        if (dbl)
        begin
            r.ph0 = "K";
            r.ph1 = "S";
            r.nph = 2'd2;
        end
        else if (emit)
        begin
            r.ph0 = p;
            r.nph = 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mpe_if.sv =====
// ----------------------------------------------------------------------------
// mpe_if
// Channel interfaces: word bytes in, key results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_of_word;
    modport source (output valid, output char_in, output last_of_word, input ready);
    modport sink   (input valid, input char_in, input last_of_word, output ready);
endinterface

interface mpe_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] phoneme;
    logic       has_phoneme;
    logic       end_of_word;
    modport source (output valid, output phoneme, output has_phoneme, output end_of_word,
                    input ready);
    modport sink   (input valid, input phoneme, input has_phoneme, input end_of_word,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/mpe_front.sv =====
// ----------------------------------------------------------------------------
// mpe_front
// Takes word bytes, keeps the window and encodes one position per cycle while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata,
    mpe_char_if.sink           char_ch,
    output mpe_pkg::entry_t    q_data,
    output logic               q_valid,
    input  wire logic          q_ready
);

    mpe_pkg::window_t win_reg, win_next, win_shift;
    logic             skip_reg, skip_next;
    logic [7:0]       cnt_reg, cnt_next;
    mpe_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]       flush_reg, flush_next;
    logic [7:0]       maxlen_reg;
    logic             accept, step_en, eow;
    logic [7:0]       shift_byte;
    mpe_pkg::step_t   st;
    logic [8:0]       cnt_sum;

    assign char_ch.ready = (flush_reg == 2'd0) && q_ready;
    assign accept        = char_ch.valid && char_ch.ready;

    always_comb
    begin
        step_en    = 1'b0;
        shift_byte = 8'd0;
        eow        = 1'b0;
        if (flush_reg != 2'd0)
        begin
            step_en = q_ready;
            eow     = (flush_reg == 2'd1);
        end
        else if (accept && char_ch.char_in != 8'd0)
        begin
            step_en    = 1'b1;
            shift_byte = mpe_pkg::upcase(char_ch.char_in);
        end
    end

    assign win_shift = {shift_byte, win_reg[7:1]};
    assign st        = mpe_pkg::encode(win_shift, skip_reg, phase_reg, cnt_reg, maxlen_reg);
    assign cnt_sum   = {1'b0, cnt_reg} + {7'd0, st.nph};

    assign q_valid    = step_en && (st.nph != 2'd0 || eow);
    assign q_data.ph0 = st.ph0;
    assign q_data.ph1 = st.ph1;
    assign q_data.nph = st.nph;
    assign q_data.eow = eow;

    always_comb
    begin
        win_next   = win_reg;
        skip_next  = skip_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        flush_next = flush_reg;
        if (step_en)
        begin
            win_next   = win_shift;
            skip_next  = st.skip;
            cnt_next   = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];
            phase_next = st.phase;
        end
        if (accept && (char_ch.char_in == 8'd0 || char_ch.last_of_word))
        begin
            flush_next = 2'd3;
        end
        else if (step_en && flush_reg != 2'd0)
        begin
            flush_next = flush_reg - 2'd1;
        end
        if (step_en && eow)
        begin
            win_next   = '0;
            skip_next  = 1'b0;
            cnt_next   = 8'd0;
            phase_next = mpe_pkg::PHASE_LEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            skip_reg   <= 1'b0;
            cnt_reg    <= 8'd0;
            phase_reg  <= mpe_pkg::PHASE_LEAD;
            flush_reg  <= 2'd0;
            maxlen_reg <= 8'd0;
        end
        else
        begin
            win_reg   <= win_next;
            skip_reg  <= skip_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            flush_reg <= flush_next;
            if (cfg_we)
            begin
                maxlen_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/mpe_queue.sv =====
// ----------------------------------------------------------------------------
// mpe_queue
// Short FIFO of encoded positions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mpe_pkg::entry_t  wr_data,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    output mpe_pkg::entry_t       rd_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready
);

    mpe_pkg::entry_t                mem [mpe_pkg::QUEUE_DEPTH];
    logic [mpe_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [mpe_pkg::QPTR_W:0]       count_reg, count_next;
    logic                           push, pop;

    assign wr_ready = (count_reg != (mpe_pkg::QPTR_W+1)'(mpe_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/mpe_back.sv =====
// ----------------------------------------------------------------------------
// mpe_back
// Unpacks queued positions into single key results behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mpe_pkg::entry_t  q_data,
    input  wire logic             q_valid,
    output logic                  q_ready,
    mpe_key_if.source             key_ch
);

    mpe_pkg::entry_t cur_reg;
    logic            cur_valid_reg, cur_valid_next;
    logic [1:0]      pos_reg, pos_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      ph_reg, ph_next;
    logic            has_reg, has_next, eow_reg, eow_next;
    logic            slot_free, emit, last_beat;

    assign slot_free = !out_valid_reg || key_ch.ready;
    assign emit      = cur_valid_reg && slot_free;
    assign last_beat = (pos_reg == cur_reg.nph)
                    || ((pos_reg + 2'd1) == cur_reg.nph && !cur_reg.eow);
    assign q_ready   = !cur_valid_reg || (emit && last_beat);

    always_comb
    begin
        out_valid_next = out_valid_reg && !key_ch.ready;
        ph_next        = ph_reg;
        has_next       = has_reg;
        eow_next       = eow_reg;
        pos_next       = pos_reg;
        cur_valid_next = cur_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (pos_reg < cur_reg.nph)
            begin
                ph_next  = (pos_reg == 2'd0) ? cur_reg.ph0 : cur_reg.ph1;
                has_next = 1'b1;
                eow_next = 1'b0;
            end
            else
            begin
                ph_next  = 8'd0;
                has_next = 1'b0;
                eow_next = 1'b1;
            end
            pos_next = pos_reg + 2'd1;
            if (last_beat)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_valid && q_ready)
        begin
            cur_valid_next = 1'b1;
            pos_next       = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cur_reg <= q_data;
        end
        ph_reg  <= ph_next;
        has_reg <= has_next;
        eow_reg <= eow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign key_ch.valid       = out_valid_reg;
    assign key_ch.phoneme     = ph_reg;
    assign key_ch.has_phoneme = has_reg;
    assign key_ch.end_of_word = eow_reg;

endmodule

`default_nettype wire

// ===== sv/metaphone_phonetic_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// metaphone_phonetic_encoder_unit
// Streaming traditional Metaphone key encoder.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the four-entry queue has room; each byte
// encodes one window position in that cycle. A word end drains the
// look-ahead, during which no byte is taken. The output side gives one
// result per cycle while the receiver is ready, so an X (two phonemes) or
// a word end sets the sustained rate.
`default_nettype none

module metaphone_phonetic_encoder_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    mpe_char_if.sink        char_ch,
    mpe_key_if.source       key_ch
);

    mpe_pkg::entry_t fq_data, qb_data;
    logic            fq_valid, fq_ready, qb_valid, qb_ready;

    mpe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .char_ch   (char_ch),
        .q_data    (fq_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready)
    );

    mpe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (fq_data),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .rd_data  (qb_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready)
    );

    mpe_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (qb_data),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .key_ch  (key_ch)
    );

endmodule

`default_nettype wire
